FILE: src/cste_pkg.sv
package cste_pkg;

	// Table sizes
	localparam int MAX_PROCS = 16;

	// Sequencer states of the tick engine
	typedef enum logic [3:0] {
		S_IDLE,
		S_RST_RD,
		S_RST_WR,
		S_CHK,
		S_ARR,
		S_SEL,
		S_PICK,
		S_PREEMPT,
		S_SJF,
		S_SHIFT,
		S_RUN,
		S_RUN_WR,
		S_IO,
		S_IO_WR,
		S_FIN,
		S_OUT
	} state_t;

	// Input operation codes
	localparam logic [1:0] FUNC_HEADER  = 2'd0;
	localparam logic [1:0] FUNC_BURST   = 2'd1;
	localparam logic [1:0] FUNC_TICK    = 2'd2;
	localparam logic [1:0] FUNC_RESTART = 2'd3;

	// Scheduling policies
	localparam logic [2:0] POL_FCFS = 3'd0;
	localparam logic [2:0] POL_SJF  = 3'd1;
	localparam logic [2:0] POL_SRTF = 3'd2;
	localparam logic [2:0] POL_PRIO = 3'd3;
	localparam logic [2:0] POL_RR   = 3'd4;

	// End-of-tick kinds
	localparam logic [1:0] END_NONE    = 2'd0;
	localparam logic [1:0] END_IO      = 2'd1;
	localparam logic [1:0] END_FINISH  = 2'd2;
	localparam logic [1:0] END_QUANTUM = 2'd3;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_POLICY  = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_PCOUNT  = 2'd2;

endpackage

FILE: src/cpu_scheduler_tick_engine.sv
// CPU scheduling tick engine. Load process headers (func 0) and bursts (func 1),
// restart the run (func 3), then issue ticks (func 2); each tick returns one
// result transfer. A restart is a sweep that reloads every first CPU burst from
// the burst RAM. A tick scans the processes taking part, with an extra write
// step per process returning from I/O and one when the running burst ends into
// I/O; SRTF and priority add a selection scan over the processes, SJF a scan and
// compaction of the ready queue. All of this steps through one process or
// queue slot per cycle; the burst RAM read is registered.
module cpu_scheduler_tick_engine #(
	parameter int MAX_BURST_SLOTS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  proc_index,
	input  logic [4:0]  slot_index,
	input  logic [15:0] burst_length,
	input  logic [7:0]  priority_req,
	input  logic [15:0] arrival,
	input  logic [4:0]  burst_count,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] time_res,
	output logic        running_valid,
	output logic [3:0]  running_proc,
	output logic        preempted_valid,
	output logic [3:0]  preempted_proc,
	output logic [1:0]  end_kind,
	output logic [31:0] turnaround,
	output logic        all_done
);

	import cste_pkg::*;

	localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int SW    = $clog2(MAX_BURST_SLOTS) + 1;
	localparam int DEPTH = MAX_PROCS * MAX_BURST_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [PW:0] NONE = (PW+1)'(MAX_PROCS);

	// configuration registers
	logic [2:0] policy_q;
	logic [7:0] quantum_q;
	logic [4:0] pcount_q;

	// per-process state
	logic [7:0]  pri_q  [MAX_PROCS];
	logic [15:0] arr_q  [MAX_PROCS];
	logic [4:0]  cnt_q  [MAX_PROCS];
	logic [7:0]  pos_q  [MAX_PROCS];
	logic [15:0] rem_q  [MAX_PROCS];
	logic [15:0] io_q   [MAX_PROCS];
	logic        fin_q  [MAX_PROCS];
	logic [PW-1:0] queue_q [MAX_PROCS];

	// run state
	state_t      state_q, state_d;
	logic [PW-1:0] head_q;
	logic [PW:0]   qcount_q;
	logic [31:0]   clock_q;
	logic [PW:0]   cur_q;
	logic [PW:0]   sel_q;
	logic [PW:0]   going_q;
	logic [7:0]    slice_q;
	logic [PW:0]   total_q;
	logic [PW-1:0] idx_q;
	logic [PW:0]   k_q;
	logic [PW-1:0] best_q;
	logic          oob_q;

	// tick result under construction
	logic [31:0]   r_time_q;
	logic          r_run_v_q;
	logic [3:0]    r_run_p_q;
	logic          r_pre_v_q;
	logic [3:0]    r_pre_p_q;
	logic [1:0]    r_end_q;
	logic [31:0]   r_turn_q;
	logic          r_done_q;

	// burst RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_rdata;

	function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p, input logic [SW-1:0] s);
		slot_addr = AW'(int'(p) * MAX_BURST_SLOTS + int'(s));
	endfunction

	function automatic logic [PW-1:0] qwrap(input logic [PW+1:0] a);
		logic [PW+1:0] m;
		m = (PW+2)'(MAX_PROCS);
		qwrap = (a >= m) ? PW'(a - m) : PW'(a);
	endfunction

	// derived control values
	logic          accept;
	logic [2:0]    pol;
	logic [PW:0]   n_act;
	logic          last_idx;
	logic [PW-1:0] c_idx;
	logic [PW-1:0] s_idx;
	logic          elig, better;
	logic [15:0]   run_rem;
	logic [8:0]    pos_n;
	logic [4:0]    list_len;
	logic          run_fin;
	logic [7:0]    slice_n;
	logic          run_quant;
	logic          preempt;
	logic [PW-1:0] qa_idx, qb_idx;
	logic          sjf_less;
	logic [15:0]   io_dec;
	logic          io_act;
	logic          enq_en;
	logic [PW-1:0] enq_val;
	logic          enq_ok;

	assign accept = in_valid && !in_stall;
	assign pol    = (policy_q > POL_RR) ? POL_FCFS : policy_q;
	assign n_act  = (int'(pcount_q) > MAX_PROCS) ? NONE : (PW+1)'(pcount_q);
	assign last_idx = ((PW+1)'(idx_q) == n_act - 1'b1);
	assign c_idx  = cur_q[PW-1:0];
	assign s_idx  = sel_q[PW-1:0];

	// selection compare for SRTF and priority
	always_comb begin
		elig = !fin_q[idx_q] && (io_q[idx_q] == '0) &&
			({16'd0, arr_q[idx_q]} <= clock_q) && (rem_q[idx_q] != '0);
		if (sel_q == NONE) begin
			better = 1'b1;
		end else if (pol == POL_SRTF) begin
			better = rem_q[idx_q] < rem_q[s_idx];
		end else begin
			better = (pri_q[idx_q] > pri_q[s_idx]) ||
				((pri_q[idx_q] == pri_q[s_idx]) && (arr_q[idx_q] < arr_q[s_idx]));
		end
	end

	// running process arithmetic
	always_comb begin
		run_rem   = rem_q[c_idx] - 16'd1;
		pos_n     = {1'b0, pos_q[c_idx]} + 9'd1;
		list_len  = (int'(cnt_q[c_idx]) > MAX_BURST_SLOTS) ?
			5'(MAX_BURST_SLOTS) : cnt_q[c_idx];
		run_fin   = (pos_n + 9'd1) >= {4'd0, list_len};
		slice_n   = slice_q + 8'd1;
		run_quant = (pol == POL_RR) && (slice_n == quantum_q);
		preempt   = (cur_q != NONE) && (sel_q != cur_q) && (rem_q[c_idx] != '0);
	end

	// SJF queue compare and I/O countdown step
	always_comb begin
		qa_idx   = queue_q[qwrap((PW+2)'(head_q) + (PW+2)'(k_q))];
		qb_idx   = queue_q[qwrap((PW+2)'(head_q) + (PW+2)'(best_q))];
		sjf_less = rem_q[qa_idx] < rem_q[qb_idx];
		io_dec   = io_q[idx_q] - 16'd1;
		io_act   = (io_q[idx_q] != '0) && ((PW+1)'(idx_q) != going_q);
	end

	// ready-queue insertion requests
	always_comb begin
		enq_en  = 1'b0;
		enq_val = idx_q;
		unique case (state_q)
			S_ARR:     enq_en = ({16'd0, arr_q[idx_q]} == clock_q);
			S_PREEMPT: begin
				enq_en  = preempt && (pol == POL_SRTF);
				enq_val = c_idx;
			end
			S_RUN: begin
				enq_en  = (cur_q != NONE) && (run_rem != '0) && run_quant;
				enq_val = c_idx;
			end
			S_IO_WR:   enq_en = 1'b1;
			default:   enq_en = 1'b0;
		endcase
		enq_ok = enq_en && (qcount_q < NONE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func == FUNC_RESTART) state_d = S_RST_RD;
				else if (accept && func == FUNC_TICK) state_d = S_CHK;
			end
			S_RST_RD: state_d = S_RST_WR;
			S_RST_WR: state_d = (int'(idx_q) == MAX_PROCS - 1) ? S_IDLE : S_RST_RD;
			S_CHK:    state_d = (total_q >= n_act) ? S_OUT : S_ARR;
			S_ARR:    state_d = last_idx ? S_SEL : S_ARR;
			S_SEL: begin
				if (pol == POL_SRTF || pol == POL_PRIO) state_d = S_PICK;
				else if (cur_q == NONE && qcount_q != '0 && pol == POL_SJF) state_d = S_SJF;
				else state_d = S_RUN;
			end
			S_PICK:    state_d = last_idx ? S_PREEMPT : S_PICK;
			S_PREEMPT: state_d = S_RUN;
			S_SJF:     state_d = (k_q < qcount_q) ? S_SJF : S_SHIFT;
			S_SHIFT:   state_d = ((k_q + 1'b1) < qcount_q) ? S_SHIFT : S_RUN;
			S_RUN: begin
				if (cur_q != NONE && run_rem == '0 && !run_fin) state_d = S_RUN_WR;
				else state_d = S_IO;
			end
			S_RUN_WR:  state_d = S_IO;
			S_IO: begin
				if (io_act && io_dec == '0) state_d = S_IO_WR;
				else if (last_idx) state_d = S_FIN;
			end
			S_IO_WR:   state_d = last_idx ? S_FIN : S_IO;
			S_FIN:     state_d = S_OUT;
			S_OUT:     state_d = (!out_valid || !out_stall) ? S_IDLE : S_OUT;
			default:   state_d = S_IDLE;
		endcase
	end

	// handshake and RAM port control
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		pready    = 1'b1;
		ram_we    = accept && (func == FUNC_BURST) && (int'(proc_index) < MAX_PROCS) &&
			(int'(slot_index) < MAX_BURST_SLOTS);
		ram_waddr = slot_addr(PW'(proc_index), SW'(slot_index));
		unique case (state_q)
			S_RUN:   ram_raddr = slot_addr(c_idx, SW'(pos_n));
			S_IO:    ram_raddr = slot_addr(idx_q, SW'(pos_q[idx_q]));
			default: ram_raddr = slot_addr(idx_q, '0);
		endcase
	end

	cste_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_burst_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (burst_length),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration write and read back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_FCFS;
			quantum_q <= 8'd4;
			pcount_q  <= 5'd1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_POLICY:  policy_q  <= pwdata[2:0];
				REG_QUANTUM: quantum_q <= pwdata[7:0];
				REG_PCOUNT:  pcount_q  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_POLICY:  prdata = {29'd0, policy_q};
			REG_QUANTUM: prdata = {24'd0, quantum_q};
			REG_PCOUNT:  prdata = {27'd0, pcount_q};
			default:     prdata = '0;
		endcase
	end

	// process headers and ready queue slots
	always_ff @(posedge clk) begin
		if (accept && func == FUNC_HEADER && int'(proc_index) < MAX_PROCS) begin
			pri_q[PW'(proc_index)] <= priority_req;
			arr_q[PW'(proc_index)] <= arrival;
			cnt_q[PW'(proc_index)] <= burst_count;
		end
		if (enq_ok) begin
			queue_q[qwrap((PW+2)'(head_q) + (PW+2)'(qcount_q))] <= enq_val;
		end else if (state_q == S_SHIFT && (k_q + 1'b1) < qcount_q) begin
			queue_q[qwrap((PW+2)'(head_q) + (PW+2)'(k_q))] <=
				queue_q[qwrap((PW+2)'(head_q) + (PW+2)'(k_q) + 1'b1)];
		end
	end

	// per-process run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PROCS; i++) begin
				pos_q[i] <= '0;
				rem_q[i] <= '0;
				io_q[i]  <= '0;
				fin_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && func == FUNC_RESTART) begin
						for (int i = 0; i < MAX_PROCS; i++) begin
							pos_q[i] <= '0;
							io_q[i]  <= '0;
							fin_q[i] <= 1'b0;
						end
					end
				end
				S_RST_WR: rem_q[idx_q] <= ram_rdata;
				S_RUN: begin
					if (cur_q != NONE) begin
						rem_q[c_idx] <= run_rem;
						if (run_rem == '0) begin
							if (run_fin) begin
								pos_q[c_idx] <= pos_n[7:0];
								fin_q[c_idx] <= 1'b1;
							end else begin
								pos_q[c_idx] <= pos_n[7:0] + 8'd1;
							end
						end
					end
				end
				S_RUN_WR: io_q[going_q[PW-1:0]] <= ram_rdata;
				S_IO: if (io_act) io_q[idx_q] <= io_dec;
				S_IO_WR: rem_q[idx_q] <= oob_q ? 16'd0 : ram_rdata;
				default: ;
			endcase
		end
	end

	// sequencer, queue pointers and tick result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			qcount_q  <= '0;
			clock_q   <= '0;
			cur_q     <= NONE;
			sel_q     <= NONE;
			going_q   <= NONE;
			slice_q   <= '0;
			total_q   <= '0;
			idx_q     <= '0;
			k_q       <= '0;
			best_q    <= '0;
			oob_q     <= 1'b0;
			r_time_q  <= '0;
			r_run_v_q <= 1'b0;
			r_run_p_q <= '0;
			r_pre_v_q <= 1'b0;
			r_pre_p_q <= '0;
			r_end_q   <= END_NONE;
			r_turn_q  <= '0;
			r_done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (enq_ok) qcount_q <= qcount_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept && func == FUNC_RESTART) begin
						clock_q  <= '0;
						cur_q    <= NONE;
						total_q  <= '0;
						head_q   <= '0;
						qcount_q <= '0;
						slice_q  <= '0;
					end
				end
				S_RST_RD: ;
				S_RST_WR: idx_q <= idx_q + 1'b1;
				S_CHK: begin
					r_time_q  <= clock_q;
					r_run_v_q <= 1'b0;
					r_run_p_q <= '0;
					r_pre_v_q <= 1'b0;
					r_pre_p_q <= '0;
					r_end_q   <= END_NONE;
					r_turn_q  <= '0;
					r_done_q  <= (total_q >= n_act);
					going_q   <= NONE;
					sel_q     <= NONE;
					idx_q     <= '0;
				end
				S_ARR: idx_q <= last_idx ? '0 : idx_q + 1'b1;
				S_SEL: begin
					k_q    <= (PW+1)'(1);
					best_q <= '0;
					if (pol != POL_SRTF && pol != POL_PRIO && cur_q == NONE &&
						qcount_q != '0 && pol != POL_SJF) begin
						cur_q    <= {1'b0, queue_q[head_q]};
						head_q   <= qwrap((PW+2)'(head_q) + 1'b1);
						qcount_q <= qcount_q - 1'b1;
						slice_q  <= '0;
					end
				end
				S_PICK: begin
					if (elig && better) sel_q <= (PW+1)'(idx_q);
					idx_q <= last_idx ? '0 : idx_q + 1'b1;
				end
				S_PREEMPT: begin
					if (preempt) begin
						r_pre_v_q <= 1'b1;
						r_pre_p_q <= 4'(c_idx);
					end
					cur_q <= sel_q;
				end
				S_SJF: begin
					if (k_q < qcount_q) begin
						if (sjf_less) best_q <= PW'(k_q);
						k_q <= k_q + 1'b1;
					end else begin
						cur_q <= {1'b0, qb_idx};
						k_q   <= (PW+1)'(best_q);
					end
				end
				S_SHIFT: begin
					if ((k_q + 1'b1) < qcount_q) begin
						k_q <= k_q + 1'b1;
					end else begin
						qcount_q <= qcount_q - 1'b1;
						slice_q  <= '0;
					end
				end
				S_RUN: begin
					idx_q <= '0;
					if (cur_q != NONE) begin
						r_run_v_q <= 1'b1;
						r_run_p_q <= 4'(c_idx);
						if (pol == POL_RR) slice_q <= slice_n;
						if (run_rem == '0) begin
							cur_q <= NONE;
							if (run_fin) begin
								if (!fin_q[c_idx]) total_q <= total_q + 1'b1;
								r_end_q  <= END_FINISH;
								r_turn_q <= clock_q + 32'd1 - {16'd0, arr_q[c_idx]};
							end else begin
								going_q <= cur_q;
								r_end_q <= END_IO;
							end
						end else if (run_quant) begin
							r_end_q <= END_QUANTUM;
							cur_q   <= NONE;
						end
					end
				end
				S_RUN_WR: ;
				S_IO: begin
					oob_q <= (int'(pos_q[idx_q]) >= MAX_BURST_SLOTS);
					if (!(io_act && io_dec == '0) && !last_idx) idx_q <= idx_q + 1'b1;
				end
				S_IO_WR: if (!last_idx) idx_q <= idx_q + 1'b1;
				S_FIN: begin
					clock_q  <= clock_q + 32'd1;
					r_done_q <= (total_q >= n_act);
				end
				S_OUT: ;
				default: ;
			endcase
		end
	end

	// result register, free to take a new tick while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid || !out_stall)) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid || !out_stall)) begin
			time_res        <= r_time_q;
			running_valid   <= r_run_v_q;
			running_proc    <= r_run_p_q;
			preempted_valid <= r_pre_v_q;
			preempted_proc  <= r_pre_p_q;
			end_kind        <= r_end_q;
			turnaround      <= r_turn_q;
			all_done        <= r_done_q;
		end
	end

endmodule

FILE: src/cste_ram.sv
module cste_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/cste_checker.sv
module cste_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] time_res,
	input logic        running_valid,
	input logic [3:0]  running_proc,
	input logic        preempted_valid,
	input logic [3:0]  preempted_proc,
	input logic [1:0]  end_kind,
	input logic [31:0] turnaround
);

	import cste_pkg::*;

	// a stalled result holds its time stamp
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(time_res))
		else $error("stalled result changed");

	// no process reported when nothing ran
	a_idle_proc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running_valid |-> running_proc == '0 && end_kind == END_NONE)
		else $error("idle tick reports a process");

	// turnaround only on a finish
	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_kind != END_FINISH |-> turnaround == '0)
		else $error("turnaround without finish");

	// preempted process is zero when no preemption
	a_pre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !preempted_valid |-> preempted_proc == '0)
		else $error("preempted process without preemption");

endmodule

bind cpu_scheduler_tick_engine cste_checker u_cste_checker (.*);

FILE: tb/testbench.sv
module testbench;
	import cste_pkg::*;

	localparam int NPROC  = 16;
	localparam int NSLOT  = 20;
	localparam int NONE   = 16;
	localparam int N_PH   = 10;

	// one input transfer
	typedef struct {
		logic [1:0]  f;
		logic [3:0]  p;
		logic [4:0]  s;
		logic [15:0] bl;
		logic [7:0]  pr;
		logic [15:0] ar;
		logic [4:0]  bc;
	} sched_op_t;

	// one tick report
	typedef struct packed {
		logic [31:0] t;
		logic        rv;
		logic [3:0]  rp;
		logic        pv;
		logic [3:0]  pp;
		logic [1:0]  ek;
		logic [31:0] ta;
		logic        ad;
	} tick_rep_t;

	// directed row: typed = 1 means the report below is checked as written
	typedef struct {
		sched_op_t op;
		bit        typed;
		tick_rep_t rep;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_stall;
	logic [1:0]  func;
	logic [3:0]  proc_index;
	logic [4:0]  slot_index;
	logic [15:0] burst_length;
	logic [7:0]  priority_req;
	logic [15:0] arrival;
	logic [4:0]  burst_count;
	logic        out_valid, out_stall;
	logic [31:0] time_res;
	logic        running_valid;
	logic [3:0]  running_proc;
	logic        preempted_valid;
	logic [3:0]  preempted_proc;
	logic [1:0]  end_kind;
	logic [31:0] turnaround;
	logic        all_done;

	cpu_scheduler_tick_engine dut (.*);

	// scheduler shadow state
	logic [15:0] sh_burst [NPROC][NSLOT];
	logic [7:0]  sh_prio [NPROC];
	logic [15:0] sh_arr [NPROC];
	logic [4:0]  sh_cnt [NPROC];
	int          sh_pos [NPROC];
	logic [15:0] sh_rem [NPROC];
	logic [15:0] sh_iow [NPROC];
	bit          sh_fin [NPROC];
	int          sh_rq [NPROC];
	int          q_head, q_cnt;
	logic [31:0] sh_clk;
	int          sh_cur;
	logic [7:0]  sh_slice;
	int          sh_ftot;
	logic [2:0]  cfg_pol;
	logic [7:0]  cfg_quant;
	logic [4:0]  cfg_pcnt;

	tick_rep_t   pending_reps[$];
	int          n_bad;
	int          n_sent;
	int          send_idle, recv_stall, hold_cycles;

	function automatic logic [15:0] burst_of(int p, int s);
		if (s >= NSLOT) return 16'd0;
		return sh_burst[p][s];
	endfunction

	function automatic int list_len(int p);
		return sh_cnt[p] > NSLOT ? NSLOT : int'(sh_cnt[p]);
	endfunction

	function automatic void q_push(int p);
		if (q_cnt >= NPROC) return;
		sh_rq[(q_head + q_cnt) % NPROC] = p;
		q_cnt++;
	endfunction

	function automatic int q_take_head();
		int p;
		p = sh_rq[q_head];
		q_head = (q_head + 1) % NPROC;
		q_cnt--;
		return p;
	endfunction

	// SJF: least remaining in queue, earliest position on a tie, then close the gap
	function automatic int q_take_shortest();
		int best, p;
		best = 0;
		for (int k = 1; k < q_cnt; k++)
			if (sh_rem[sh_rq[(q_head + k) % NPROC]] < sh_rem[sh_rq[(q_head + best) % NPROC]])
				best = k;
		p = sh_rq[(q_head + best) % NPROC];
		for (int k = best; k + 1 < q_cnt; k++)
			sh_rq[(q_head + k) % NPROC] = sh_rq[(q_head + k + 1) % NPROC];
		q_cnt--;
		return p;
	endfunction

	function automatic bit can_run(int i);
		return !sh_fin[i] && sh_iow[i] == 0 && {16'd0, sh_arr[i]} <= sh_clk && sh_rem[i] > 0;
	endfunction

	function automatic int pick_srtf(int n);
		int sel;
		sel = NONE;
		for (int i = 0; i < n; i++)
			if (can_run(i) && (sel == NONE || sh_rem[i] < sh_rem[sel])) sel = i;
		return sel;
	endfunction

	function automatic int pick_prio(int n);
		int sel;
		sel = NONE;
		for (int i = 0; i < n; i++)
			if (can_run(i) && (sel == NONE || sh_prio[i] > sh_prio[sel] ||
					(sh_prio[i] == sh_prio[sel] && sh_arr[i] < sh_arr[sel])))
				sel = i;
		return sel;
	endfunction

	function automatic void rewind_run();
		sh_clk = 0; sh_cur = NONE; sh_ftot = 0;
		q_head = 0; q_cnt = 0; sh_slice = 0;
		for (int i = 0; i < NPROC; i++) begin
			sh_pos[i] = 0;
			sh_rem[i] = burst_of(i, 0);
			sh_iow[i] = 0;
			sh_fin[i] = 0;
		end
	endfunction

	// one simulated time unit; returns the report it produces
	function automatic tick_rep_t tick_predict();
		tick_rep_t r;
		int n, prev, sel, c, np, going;
		logic [2:0] pol;
		r = '0;
		going = NONE;
		r.t = sh_clk;
		n = cfg_pcnt > NPROC ? NPROC : int'(cfg_pcnt);
		if (sh_ftot >= n) begin
			r.ad = 1'b1;
			return r;
		end
		for (int i = 0; i < n; i++)
			if ({16'd0, sh_arr[i]} == sh_clk) q_push(i);
		pol = cfg_pol > POL_RR ? POL_FCFS : cfg_pol;
		if (pol == POL_SRTF || pol == POL_PRIO) begin
			prev = sh_cur;
			sel = pol == POL_SRTF ? pick_srtf(n) : pick_prio(n);
			if (prev < NONE && sel != prev && sh_rem[prev] > 0) begin
				r.pv = 1'b1;
				r.pp = prev[3:0];
				if (pol == POL_SRTF) q_push(prev);
			end
			sh_cur = sel;
		end else if (sh_cur >= NONE && q_cnt > 0) begin
			sh_cur = pol == POL_SJF ? q_take_shortest() : q_take_head();
			sh_slice = 0;
		end
		if (sh_cur < NONE) begin
			c = sh_cur;
			r.rv = 1'b1;
			r.rp = c[3:0];
			sh_rem[c] = sh_rem[c] - 16'd1;
			if (pol == POL_RR) sh_slice = sh_slice + 8'd1;
			if (sh_rem[c] == 0) begin
				np = sh_pos[c] + 1;
				if (np + 1 >= list_len(c)) begin
					sh_pos[c] = np;
					if (!sh_fin[c]) sh_ftot++;
					sh_fin[c] = 1;
					r.ek = END_FINISH;
					r.ta = sh_clk + 32'd1 - {16'd0, sh_arr[c]};
				end else begin
					sh_iow[c] = burst_of(c, np);
					sh_pos[c] = np + 1;
					going = c;
					r.ek = END_IO;
				end
				sh_cur = NONE;
			end else if (pol == POL_RR && sh_slice == cfg_quant) begin
				r.ek = END_QUANTUM;
				q_push(c);
				sh_cur = NONE;
			end
		end
		// I/O countdown
		for (int i = 0; i < n; i++)
			if (sh_iow[i] > 0 && i != going) begin
				sh_iow[i] = sh_iow[i] - 16'd1;
				if (sh_iow[i] == 0) begin
					sh_rem[i] = burst_of(i, sh_pos[i]);
					q_push(i);
				end
			end
		sh_clk = sh_clk + 32'd1;
		r.ad = sh_ftot >= n;
		return r;
	endfunction

	// apply an accepted transfer to the shadow state; 1 when a report is due
	function automatic bit apply_op(sched_op_t o, output tick_rep_t r);
		r = '0;
		case (o.f)
			FUNC_HEADER: begin
				sh_prio[o.p] = o.pr;
				sh_arr[o.p] = o.ar;
				sh_cnt[o.p] = o.bc;
			end
			FUNC_BURST: if (o.s < NSLOT) sh_burst[o.p][o.s] = o.bl;
			FUNC_RESTART: rewind_run();
			default: begin
				r = tick_predict();
				return 1;
			end
		endcase
		return 0;
	endfunction

	task automatic send(sched_op_t o, bit typed = 0, tick_rep_t ty = '0);
		tick_rep_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= o.f; proc_index <= o.p; slot_index <= o.s;
		burst_length <= o.bl; priority_req <= o.pr; arrival <= o.ar; burst_count <= o.bc;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (apply_op(o, r)) pending_reps.push_back(typed ? ty : r);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_POLICY:  cfg_pol = v[2:0];
			REG_QUANTUM: cfg_quant = v[7:0];
			default:     cfg_pcnt = v[4:0];
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_reps.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_burst();
		int r;
		r = $urandom_range(99);
		if (r < 3) return 16'd0;
		if (r < 5) return 16'($urandom);
		return 16'($urandom_range(1, 6));
	endfunction

	function automatic sched_op_t mk(logic [1:0] f, int p = 0, int s = 0, int bl = 0,
			int pr = 0, int ar = 0, int bc = 0);
		sched_op_t o;
		o.f = f; o.p = 4'(p); o.s = 5'(s); o.bl = 16'(bl); o.pr = 8'(pr);
		o.ar = 16'(ar); o.bc = 5'(bc);
		return o;
	endfunction

	function automatic tick_rep_t rep(int t, bit rv, int rp, int ek, int ta, bit ad);
		tick_rep_t r;
		r = '0;
		r.t = 32'(t); r.rv = rv; r.rp = 4'(rp); r.ek = 2'(ek); r.ta = 32'(ta); r.ad = ad;
		return r;
	endfunction

	task automatic load_proc(int p);
		int bc;
		bc = $urandom_range(99) < 5 ? $urandom_range(0, 31) : $urandom_range(1, 7);
		send(mk(FUNC_HEADER, p, 0, 0, $urandom_range(0, 255),
			$urandom_range(99) < 4 ? $urandom_range(0, 65535) : $urandom_range(0, 20), bc));
		for (int s = 0; s < (bc > NSLOT ? NSLOT : bc); s++)
			send(mk(FUNC_BURST, p, s, rnd_burst()));
	endtask

	task automatic note_bad(string what, tick_rep_t e, tick_rep_t g);
		if (n_bad < 10)
			$display("%s: exp t=%0d run=%0b/%0d pre=%0b/%0d end=%0d ta=%0d done=%0b | got t=%0d run=%0b/%0d pre=%0b/%0d end=%0d ta=%0d done=%0b",
				what, e.t, e.rv, e.rp, e.pv, e.pp, e.ek, e.ta, e.ad,
				g.t, g.rv, g.rp, g.pv, g.pp, g.ek, g.ta, g.ad);
		n_bad++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ends a hung run
	initial begin
		#40000000;
		$display("end of test: mismatches");
		$finish;
	end

	// result side: stall pattern and the long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
		out_stall <= hold_cycles > 0 || $urandom_range(99) < recv_stall;
	end

	// result check against the oldest pending report
	always @(posedge clk) begin
		tick_rep_t g, e;
		if (arst_n && out_valid && !out_stall) begin
			g = '{time_res, running_valid, running_proc, preempted_valid, preempted_proc,
				end_kind, turnaround, all_done};
			if (pending_reps.size() == 0) begin
				note_bad("unexpected report", '0, g);
			end else begin
				e = pending_reps.pop_front();
				if (g.t !== e.t || g.rv !== e.rv || g.rp !== e.rp || g.pv !== e.pv ||
						g.pp !== e.pp || g.ek !== e.ek || g.ta !== e.ta || g.ad !== e.ad)
					note_bad("report mismatch", e, g);
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t dir[$];
		logic [2:0] ph_pol [N_PH] = '{0, 1, 2, 3, 4, 4, 4, 7, 5, 2};
		logic [7:0] ph_q [N_PH] = '{4, 9, 1, 2, 1, 0, 255, 3, 4, 7};
		logic [4:0] ph_n [N_PH] = '{16, 4, 16, 8, 16, 5, 3, 31, 0, 1};
		int ne, target, nt;
		sched_op_t o;

		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; func = 0; proc_index = 0; slot_index = 0; burst_length = 0;
		priority_req = 0; arrival = 0; burst_count = 0; out_stall = 0;
		n_bad = 0; n_sent = 0; send_idle = 0; recv_stall = 0; hold_cycles = 0;
		cfg_pol = POL_FCFS; cfg_quant = 8'd4; cfg_pcnt = 5'd1;
		rewind_run();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every store so that no entry is read before it is written
		for (int p = 0; p < NPROC; p++) begin
			send(mk(FUNC_HEADER, p, 0, 0, $urandom_range(0, 255), $urandom_range(0, 20),
				$urandom_range(1, 7)));
			for (int s = 0; s < NSLOT; s++) send(mk(FUNC_BURST, p, s, $urandom_range(1, 6)));
		end

		// directed: one process with CPU, I/O, CPU bursts of one tick each
		dir.push_back('{mk(FUNC_HEADER, 0, 0, 0, 255, 0, 3), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 0, 0, 1), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 0, 1, 1), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 0, 2, 1), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 0, 31, 65535), 0, '0});
		dir.push_back('{mk(FUNC_RESTART), 0, '0});
		dir.push_back('{mk(FUNC_TICK), 1, rep(0, 1, 0, END_IO, 0, 0)});
		dir.push_back('{mk(FUNC_TICK), 1, rep(1, 0, 0, END_NONE, 0, 0)});
		dir.push_back('{mk(FUNC_TICK), 1, rep(2, 1, 0, END_FINISH, 3, 1)});
		dir.push_back('{mk(FUNC_TICK), 1, rep(3, 0, 0, END_NONE, 0, 1)});
		// field extremes, empty list, out-of-range slot
		dir.push_back('{mk(FUNC_HEADER, 15, 0, 0, 0, 65535, 31), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 15, 19, 0), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 15, 20, 65535), 0, '0});
		dir.push_back('{mk(FUNC_HEADER, 0, 0, 0, 128, 1, 0), 0, '0});
		dir.push_back('{mk(FUNC_BURST, 0, 0, 2), 0, '0});
		dir.push_back('{mk(FUNC_RESTART), 0, '0});
		for (int k = 0; k < 5; k++) dir.push_back('{mk(FUNC_TICK), 0, '0});
		foreach (dir[i]) send(dir[i].op, dir[i].typed, dir[i].rep);

		// random phases: settings, usually a reload and a restart, then mostly ticks
		for (int ph = 0; ph < N_PH; ph++) begin
			drain();
			reg_write(REG_POLICY, ph_pol[ph]);
			reg_write(REG_QUANTUM, ph_q[ph]);
			reg_write(REG_PCOUNT, ph_n[ph]);
			send_idle  = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 12 : 0;
			recv_stall = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 12 : 0;
			ne = ph_n[ph] > NPROC ? NPROC : (ph_n[ph] == 0 ? NPROC : ph_n[ph]);
			target = n_sent + 50;
			if ($urandom_range(9) < 8)
				repeat ($urandom_range(1, 4)) load_proc($urandom_range(0, ne - 1));
			if (ph != 8) send(mk(FUNC_RESTART));
			if (ph == 2) hold_cycles = 500;
			nt = 0;
			while (n_sent < target) begin
				case ($urandom_range(19))
					0: send(mk(FUNC_BURST, $urandom_range(0, 15), $urandom_range(20, 31),
						$urandom_range(0, 65535)));
					1: load_proc($urandom_range(0, ne - 1));
					default: begin
						send(mk(FUNC_TICK, $urandom_range(0, 15), $urandom_range(0, 31)));
						nt++;
						if (ph == 5 && nt == 20) begin
							in_valid <= 1'b0;
							wait (pending_reps.size() == 0);
						end
					end
				endcase
			end
		end

		in_valid <= 1'b0;
		wait (pending_reps.size() == 0);
		repeat (200) @(posedge clk);
		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
src/cste_pkg.sv
src/cste_ram.sv
src/cpu_scheduler_tick_engine.sv
src/cste_checker.sv
tb/testbench.sv
